/* src/crc8_stuffed_frame_encoder_assert.svh */
// Assertion macros shared by the framer modules.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef CRC8_STUFFED_FRAME_ENCODER_ASSERT_SVH
`define CRC8_STUFFED_FRAME_ENCODER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CSFE_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("csfe assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define CSFE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("csfe assertion failed");

`endif

/* src/csfe_pkg.sv */
`default_nettype none

package csfe_pkg;

  localparam logic [7:0] FLAG_BYTE = 8'hF0;
  localparam logic [7:0] ESC_BYTE  = 8'hFE;
  localparam logic [7:0] CRC_POLY  = 8'h4D;
  localparam logic [7:0] SEQ_EVEN  = 8'h00;
  localparam logic [7:0] SEQ_ODD   = 8'h01;
  localparam logic [7:0] SEQ_LAST  = 8'h03;
  localparam logic [7:0] BLOCK_BYTES_RESET = 8'd4;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        start_of_message;
    logic [15:0] message_bytes;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_end;
    logic       last_of_run;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV,
    S_OPEN_FIRST,
    S_OPEN,
    S_FLAG,
    S_SEQ,
    S_DESC,
    S_DATA,
    S_CESC,
    S_CRC,
    S_CLOSE
  } state_t;

  typedef enum logic [2:0] {
    SEL_FLAG,
    SEL_SEQ,
    SEL_ESC,
    SEL_DATA,
    SEL_CRC,
    SEL_CLOSE
  } emit_sel_t;

  typedef struct packed {
    logic      accept;
    logic      clear;
    logic      div_load;
    logic      div_step;
    logic      open;
    logic      open_first;
    logic      consume;
    logic      close;
    logic      emit;
    emit_sel_t emit_sel;
    logic      emit_last;
  } cmd_t;

  typedef struct packed {
    logic in_start;
    logic in_len_zero;
    logic msg_open;
    logic block_zero;
    logic block_one;
    logic div_last;
    logic data_esc;
    logic crc_esc;
    logic out_free;
  } status_t;

  // One byte of CRC-8, MSB first, no reflection.
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

/* src/crc8_stuffed_frame_encoder.sv */
// CRC-8 stuffed frame encoder.
// Requests arrive on item_valid/item_ready, one message byte each; the first byte of a
// message carries start_of_message and the total length. Output bytes leave one at a
// time on result_valid/result_ready: flag, sequence byte, stuffed data, stuffed
// CRC-8 and a closing flag, with last_of_run marking the final byte of each request.
// The block works on one request at a time. A request inside a frame passes through S_DESC
// and S_DATA before the next request can be taken, whether or not its byte is escaped;
// a request that opens a further frame first passes through the open, flag and sequence
// byte states, and closing a frame adds the CRC escape check, the CRC and the closing
// flag. A starting request first runs through the one-bit-per-cycle remainder divider
// that sizes the first block, then opens the frame and sends the flag and sequence byte.
// For a byte inside a frame the first result byte is the escape from S_DESC when the byte
// is a flag or an escape, otherwise the data byte itself from S_DATA.
// Ignored requests and zero-length starts are absorbed in the acceptance cycle.
// Output bytes sit in one output register; when the receiver stalls, the sequencer waits
// and the next request is held off until the run is fully in the register.
// Synchronous reset closes any open message and empties the output register; the
// block_bytes register returns to four. Configuration is written over the APB port.

`default_nettype none

`include "crc8_stuffed_frame_encoder_assert.svh"

module crc8_stuffed_frame_encoder #(
  parameter int LENGTH_BITS = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                item_valid,
  output logic                     item_ready,
  input  wire csfe_pkg::in_item_t  item,
  output logic                     result_valid,
  input  wire logic                result_ready,
  output csfe_pkg::out_item_t      result,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [2:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);
  import csfe_pkg::*;

  logic [7:0] block_bytes;
  logic       cfg_write;
  cmd_t       cmd;
  status_t    status;

  // The only register sits at byte address zero; paddr bit 2 selects beyond it.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && !paddr[2];
  assign prdata    = paddr[2] ? 32'd0 : {24'd0, block_bytes};

  always_ff @(posedge clk) begin
    if (rst) begin
      block_bytes <= BLOCK_BYTES_RESET;
    end else if (cfg_write) begin
      block_bytes <= pwdata[7:0];
    end
  end

  csfe_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .status     (status),
    .cmd        (cmd)
  );

  csfe_dp #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .block_bytes  (block_bytes),
    .cmd          (cmd),
    .status       (status),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  // A request is only taken while nothing is being emitted for an earlier one.
  `CSFE_ASSERT_SAME(a_accept_quiet, item_valid && item_ready, !cmd.emit)

endmodule

`default_nettype wire

/* src/csfe_ctrl.sv */
`default_nettype none

`include "crc8_stuffed_frame_encoder_assert.svh"

module csfe_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              item_valid,
  output logic                   item_ready,
  input  wire csfe_pkg::status_t status,
  output csfe_pkg::cmd_t         cmd
);
  import csfe_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (item_valid) begin
          if (status.in_start && status.in_len_zero) begin
            state_next = S_IDLE;
          end else if (status.in_start) begin
            state_next = S_DIV;
          end else if (!status.msg_open) begin
            state_next = S_IDLE;
          end else if (status.block_zero) begin
            state_next = S_OPEN;
          end else begin
            state_next = S_DESC;
          end
        end
      end
      S_DIV: begin
        if (status.div_last) begin
          state_next = S_OPEN_FIRST;
        end
      end
      S_OPEN_FIRST, S_OPEN: state_next = S_FLAG;
      S_FLAG: begin
        if (status.out_free) begin
          state_next = S_SEQ;
        end
      end
      S_SEQ: begin
        if (status.out_free) begin
          state_next = S_DESC;
        end
      end
      S_DESC: begin
        if (!status.data_esc || status.out_free) begin
          state_next = S_DATA;
        end
      end
      S_DATA: begin
        if (status.out_free) begin
          state_next = status.block_one ? S_CESC : S_IDLE;
        end
      end
      S_CESC: begin
        if (!status.crc_esc || status.out_free) begin
          state_next = S_CRC;
        end
      end
      S_CRC: begin
        if (status.out_free) begin
          state_next = S_CLOSE;
        end
      end
      S_CLOSE: begin
        if (status.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    item_ready = 1'b0;
    cmd        = '0;
    cmd.emit_sel = SEL_FLAG;
    case (state)
      S_IDLE: begin
        item_ready = 1'b1;
        cmd.accept = item_valid;
        cmd.clear  = item_valid && status.in_start && status.in_len_zero;
        cmd.div_load = item_valid && status.in_start && !status.in_len_zero;
      end
      S_DIV: cmd.div_step = 1'b1;
      S_OPEN_FIRST: begin
        cmd.open       = 1'b1;
        cmd.open_first = 1'b1;
      end
      S_OPEN: cmd.open = 1'b1;
      S_FLAG: begin
        cmd.emit     = status.out_free;
        cmd.emit_sel = SEL_FLAG;
      end
      S_SEQ: begin
        cmd.emit     = status.out_free;
        cmd.emit_sel = SEL_SEQ;
      end
      S_DESC: begin
        cmd.emit     = status.data_esc && status.out_free;
        cmd.emit_sel = SEL_ESC;
      end
      S_DATA: begin
        cmd.emit      = status.out_free;
        cmd.consume   = status.out_free;
        cmd.emit_sel  = SEL_DATA;
        cmd.emit_last = !status.block_one;
      end
      S_CESC: begin
        cmd.emit     = status.crc_esc && status.out_free;
        cmd.emit_sel = SEL_ESC;
      end
      S_CRC: begin
        cmd.emit     = status.out_free;
        cmd.emit_sel = SEL_CRC;
      end
      S_CLOSE: begin
        cmd.emit      = status.out_free;
        cmd.close     = status.out_free;
        cmd.emit_sel  = SEL_CLOSE;
        cmd.emit_last = 1'b1;
      end
      default: begin
        item_ready = 1'b0;
      end
    endcase
  end

  // A byte is only loaded into the output register when that register can take it.
  `CSFE_ASSERT_SAME(a_emit_needs_room, cmd.emit, status.out_free)
  // A request that starts a message always leads into the remainder division.
  `CSFE_ASSERT_NEXT(a_start_divides, cmd.div_load, state == S_DIV)

endmodule

`default_nettype wire

/* src/csfe_dp.sv */
`default_nettype none

`include "crc8_stuffed_frame_encoder_assert.svh"

module csfe_dp #(
  parameter int LENGTH_BITS = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire csfe_pkg::in_item_t  item,
  input  wire logic [7:0]          block_bytes,
  input  wire csfe_pkg::cmd_t      cmd,
  output csfe_pkg::status_t        status,
  output logic                     result_valid,
  input  wire logic                result_ready,
  output csfe_pkg::out_item_t      result
);
  import csfe_pkg::*;

  localparam int CW = (LENGTH_BITS > 1) ? $clog2(LENGTH_BITS) : 1;

  logic [7:0]             data_hold;
  logic [LENGTH_BITS-1:0] len_hold;
  logic [LENGTH_BITS-1:0] dividend;
  logic [7:0]             rem;
  logic [CW-1:0]          div_count;
  logic [LENGTH_BITS-1:0] bytes_left;
  logic [7:0]             block_left;
  logic [7:0]             crc_reg;
  logic                   frame_odd;
  logic                   msg_open;
  logic [7:0]             seq_byte;

  logic [7:0]             bb_eff;
  logic [LENGTH_BITS-1:0] len_in;
  logic [8:0]             rem_shift;
  logic [7:0]             rem_next;
  logic [7:0]             size_first;
  logic [7:0]             size_next;
  logic [7:0]             open_size;
  logic [LENGTH_BITS-1:0] open_left;
  logic                   open_last;
  logic [7:0]             seq_next;
  logic [7:0]             crc_next;
  out_item_t              emit_item;

  assign bb_eff = (block_bytes == 8'd0) ? 8'd1 : block_bytes;
  assign len_in = LENGTH_BITS'(item.message_bytes);

  // One bit of restoring division per cycle; only the remainder is kept.
  assign rem_shift = {rem, dividend[LENGTH_BITS-1]};
  always_comb begin
    if (rem_shift >= {1'b0, bb_eff}) begin
      rem_next = 8'(rem_shift - {1'b0, bb_eff});
    end else begin
      rem_next = rem_shift[7:0];
    end
  end

  assign size_first = (rem == 8'd0) ? bb_eff : rem;
  assign size_next  = (bytes_left < LENGTH_BITS'(bb_eff)) ? bytes_left[7:0] : bb_eff;
  assign open_size  = cmd.open_first ? size_first : size_next;
  assign open_left  = cmd.open_first ? len_hold : bytes_left;
  assign open_last  = (LENGTH_BITS'(open_size) == open_left);

  always_comb begin
    if (open_last) begin
      seq_next = SEQ_LAST;
    end else if (!cmd.open_first && frame_odd) begin
      seq_next = SEQ_ODD;
    end else begin
      seq_next = SEQ_EVEN;
    end
  end

  assign crc_next = crc8_update(crc_reg, data_hold);

  always_comb begin
    emit_item.frame_end   = 1'b0;
    emit_item.last_of_run = cmd.emit_last;
    case (cmd.emit_sel)
      SEL_FLAG: emit_item.out_byte = FLAG_BYTE;
      SEL_SEQ:  emit_item.out_byte = seq_byte;
      SEL_ESC:  emit_item.out_byte = ESC_BYTE;
      SEL_DATA: emit_item.out_byte = data_hold;
      SEL_CRC:  emit_item.out_byte = crc_reg;
      SEL_CLOSE: begin
        emit_item.out_byte  = FLAG_BYTE;
        emit_item.frame_end = 1'b1;
      end
      default: emit_item.out_byte = FLAG_BYTE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      msg_open     <= 1'b0;
      bytes_left   <= '0;
      block_left   <= '0;
      crc_reg      <= '0;
      frame_odd    <= 1'b0;
      div_count    <= '0;
      result_valid <= 1'b0;
    end else begin
      if (cmd.clear) begin
        msg_open   <= 1'b0;
        bytes_left <= '0;
        block_left <= '0;
        crc_reg    <= '0;
        frame_odd  <= 1'b0;
      end else if (cmd.open) begin
        block_left <= open_size;
        crc_reg    <= '0;
        if (cmd.open_first) begin
          bytes_left <= len_hold;
          frame_odd  <= 1'b0;
          msg_open   <= 1'b1;
        end
      end else if (cmd.consume) begin
        crc_reg    <= crc_next;
        block_left <= block_left - 8'd1;
        bytes_left <= bytes_left - LENGTH_BITS'(1);
      end else if (cmd.close) begin
        crc_reg <= '0;
        if (bytes_left == '0) begin
          msg_open   <= 1'b0;
          block_left <= '0;
          frame_odd  <= 1'b0;
        end else begin
          frame_odd <= ~frame_odd;
        end
      end
      if (cmd.div_load) begin
        div_count <= '0;
      end else if (cmd.div_step) begin
        div_count <= div_count + CW'(1);
      end
      if (cmd.emit) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      data_hold <= item.data_byte;
      len_hold  <= len_in;
    end
    if (cmd.div_load) begin
      dividend <= len_in;
      rem      <= '0;
    end else if (cmd.div_step) begin
      dividend <= dividend << 1;
      rem      <= rem_next;
    end
    if (cmd.open) begin
      seq_byte <= seq_next;
    end
    if (cmd.emit) begin
      result <= emit_item;
    end
  end

  assign status.in_start    = item.start_of_message;
  assign status.in_len_zero = (len_in == '0);
  assign status.msg_open    = msg_open;
  assign status.block_zero  = (block_left == 8'd0);
  assign status.block_one   = (block_left == 8'd1);
  assign status.div_last    = (div_count == CW'(LENGTH_BITS - 1));
  assign status.data_esc    = data_hold inside {FLAG_BYTE, ESC_BYTE};
  assign status.crc_esc     = crc_reg inside {FLAG_BYTE, ESC_BYTE};
  assign status.out_free    = !result_valid || result_ready;

  // With no message open, nothing may be left over from the previous one.
  `CSFE_ASSERT_SAME(a_closed_is_empty, !msg_open, (bytes_left == '0) && (block_left == 8'd0))
  // A frame never asks for more bytes than the message still has.
  `CSFE_ASSERT_SAME(a_block_fits, msg_open, LENGTH_BITS'(block_left) <= bytes_left)
  // The closing flag is always the final byte of its request's run.
  `CSFE_ASSERT_SAME(a_close_is_last, result_valid && result.frame_end, result.last_of_run)

endmodule

`default_nettype wire

/* dv/testbench.sv */
`timescale 1ns / 1ps

// Self-checking bench for the CRC-8 stuffed frame encoder.
// Requests (one message byte each) go in on the item channel. Every accepted request is
// run through a predictor of the framer, which queues the output bytes that the request
// should cause. The result monitor compares each accepted output byte with the oldest
// queued byte, field by field.
module testbench;
  import csfe_pkg::*;

  localparam int LENGTH_BITS = 16;
  localparam logic [2:0] BLOCK_BYTES_ADDR = 3'd0;
  // A starting request passes through the remainder divider before it opens its frame,
  // so this comfortably covers the deepest piece of work in flight.
  localparam int SETTLE_CYCLES = LENGTH_BITS + 24;
  localparam int HOLD_CYCLES = 150;
  localparam int STALL_LIMIT = 2000;
  localparam int PHASE_ITEMS = 48;
  localparam int MAX_REPORTS = 100;

  // One row of the directed table. A typed_count of -1 leaves the row to the predictor;
  // otherwise typed_bytes holds the expected output bytes, the last of which closes a frame.
  typedef struct {
    in_item_t        req;
    int              typed_count;
    logic [6:0][7:0] typed_bytes;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        item_valid = 1'b0;
  logic        item_ready;
  in_item_t    item = '0;
  logic        result_valid;
  logic        result_ready = 1'b0;
  out_item_t   result;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  crc8_stuffed_frame_encoder #(.LENGTH_BITS(LENGTH_BITS)) u_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #4 clk = ~clk;

  // Predictor state: a private copy of the framer's registers and of block_bytes.
  logic [LENGTH_BITS-1:0] len_left = '0;
  logic [7:0]             blk_left = '0;
  logic [7:0]             crc_acc = '0;
  logic                   odd_frame = 1'b0;
  logic                   msg_open = 1'b0;
  logic [7:0]             blk_cfg = BLOCK_BYTES_RESET;

  out_item_t expected_bytes[$];
  stim_row_t directed_rows[$];

  int fail_count = 0;
  int stall_cycles = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_request = 1'b0;
  // Data bytes whose one-byte CRC is itself a flag or an escape, so that a one-byte
  // frame has to stuff its CRC.
  logic [7:0] crc_gives_flag;
  logic [7:0] crc_gives_esc;

  task automatic report_mismatch(input string what);
    fail_count++;
    // Printing is capped so that a badly broken block cannot flood the log.
    if (fail_count <= MAX_REPORTS)
      $display("%0t: mismatch: %s", $time, what);
  endtask

  // CRC-8, polynomial 0x4D, fed one bit at a time with the most significant bit first.
  function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    logic       fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[7] ^ b[i];
      c = {c[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
    end
    return c;
  endfunction

  function automatic logic [7:0] effective_block();
    return (blk_cfg == 8'd0) ? 8'd1 : blk_cfg;
  endfunction

  task automatic push_out(input logic [7:0] b, input logic fin);
    out_item_t o;
    o.out_byte = b;
    o.frame_end = fin;
    o.last_of_run = 1'b0;
    expected_bytes.insert(expected_bytes.size(), o);
  endtask

  // Payload bytes (data and CRC) that look like a flag or an escape get an escape first.
  task automatic push_payload(input logic [7:0] b);
    if (b == FLAG_BYTE || b == ESC_BYTE)
      push_out(ESC_BYTE, 1'b0);
    push_out(b, 1'b0);
  endtask

  task automatic open_frame(input logic [7:0] size);
    blk_left = size;
    crc_acc = 8'h00;
    push_out(FLAG_BYTE, 1'b0);
    if (blk_left == len_left)
      push_out(SEQ_LAST, 1'b0);
    else if (odd_frame)
      push_out(SEQ_ODD, 1'b0);
    else
      push_out(SEQ_EVEN, 1'b0);
  endtask

  // Works out the output bytes of one accepted request and queues them.
  task automatic encode_request(input in_item_t req);
    logic [LENGTH_BITS-1:0] len;
    logic [LENGTH_BITS-1:0] first;
    logic [7:0]             bb;
    out_item_t              tail;
    len = req.message_bytes[LENGTH_BITS-1:0];
    bb = effective_block();
    if (req.start_of_message) begin
      if (len == '0) begin
        // A zero-length start closes whatever is open and produces nothing.
        msg_open = 1'b0;
        len_left = '0;
        blk_left = '0;
        crc_acc = '0;
        odd_frame = 1'b0;
        return;
      end
      // The short remainder, if any, goes out first.
      first = len % bb;
      if (first == '0)
        first = bb;
      msg_open = 1'b1;
      len_left = len;
      odd_frame = 1'b0;
      open_frame(first[7:0]);
    end else begin
      if (!msg_open)
        return;
      if (blk_left == 8'd0)
        open_frame((len_left < bb) ? len_left[7:0] : bb);
    end
    crc_acc = crc8_next(crc_acc, req.data_byte);
    push_payload(req.data_byte);
    blk_left--;
    len_left--;
    if (blk_left == 8'd0) begin
      push_payload(crc_acc);
      push_out(FLAG_BYTE, 1'b1);
      odd_frame = ~odd_frame;
      crc_acc = 8'h00;
    end
    if (len_left == '0) begin
      msg_open = 1'b0;
      blk_left = 8'd0;
      odd_frame = 1'b0;
    end
    tail = expected_bytes[expected_bytes.size() - 1];
    expected_bytes.delete(expected_bytes.size() - 1);
    tail.last_of_run = 1'b1;
    expected_bytes.insert(expected_bytes.size(), tail);
  endtask

  task automatic add_row(input logic [7:0] b, input logic s, input logic [15:0] n,
                         input int typed_count = -1,
                         input logic [6:0][7:0] typed_bytes = '0);
    stim_row_t row;
    row.req.data_byte = b;
    row.req.start_of_message = s;
    row.req.message_bytes = n;
    row.typed_count = typed_count;
    row.typed_bytes = typed_bytes;
    directed_rows.insert(directed_rows.size(), row);
  endtask

  // Offers one request, entered and left at a falling edge. The sender may idle first.
  // Typed expectations replace what the predictor queued, but the predictor's state
  // still moves on so that later rows are predicted correctly.
  task automatic send_request(input in_item_t req, input int typed_count = -1,
                              input logic [6:0][7:0] typed_bytes = '0);
    int        mark;
    out_item_t o;
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid <= 1'b1;
    item <= req;
    do @(posedge clk); while (!item_ready);
    mark = expected_bytes.size();
    encode_request(req);
    if (typed_count >= 0) begin
      while (expected_bytes.size() > mark)
        expected_bytes.delete(expected_bytes.size() - 1);
      for (int k = 0; k < typed_count; k++) begin
        o.out_byte = typed_bytes[k];
        o.frame_end = (k == typed_count - 1);
        o.last_of_run = (k == typed_count - 1);
        expected_bytes.insert(expected_bytes.size(), o);
      end
    end
    @(negedge clk);
  endtask

  // Stops offering requests until every queued output byte has arrived.
  task automatic drain_results();
    item_valid <= 1'b0;
    do @(negedge clk); while (expected_bytes.size() != 0);
  endtask

  // Optionally writes block_bytes, then reads it back against the predictor's copy.
  task automatic access_block_bytes(input bit do_write, input logic [7:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    paddr <= BLOCK_BYTES_ADDR;
    if (do_write) begin
      pwrite <= 1'b1;
      pwdata <= {24'h0, value};
      @(negedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (!pready);
      blk_cfg = value;
      @(negedge clk);
      pwrite <= 1'b0;
      penable <= 1'b0;
    end else begin
      pwrite <= 1'b0;
    end
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {24'h0, blk_cfg})
      report_mismatch($sformatf("block_bytes reads %0h, expected %0h", prdata, blk_cfg));
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (expected_bytes.size() == 0) begin
      report_mismatch($sformatf("unexpected output byte %02h", got.out_byte));
      return;
    end
    want = expected_bytes.pop_front();
    if (got.out_byte !== want.out_byte)
      report_mismatch($sformatf("out_byte %02h, expected %02h", got.out_byte, want.out_byte));
    if (got.frame_end !== want.frame_end)
      report_mismatch($sformatf("frame_end %b on byte %02h, expected %b",
                                got.frame_end, got.out_byte, want.frame_end));
    if (got.last_of_run !== want.last_of_run)
      report_mismatch($sformatf("last_of_run %b on byte %02h, expected %b",
                                got.last_of_run, got.out_byte, want.last_of_run));
  endtask

  function automatic logic [7:0] pick_data();
    case ($urandom_range(19))
      0: return FLAG_BYTE;
      1: return ESC_BYTE;
      2: return crc_gives_flag;
      3: return crc_gives_esc;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [15:0] pick_length();
    int r;
    r = $urandom_range(99);
    if (r < 65)
      return 16'($urandom_range(8, 1));
    else if (r < 90)
      return 16'($urandom_range(30, 9));
    else
      return 16'($urandom_range(60, 31));
  endfunction

  // Output bytes are checked at the rising edge, and the watchdog counter is cleared
  // whenever either channel moves a byte.
  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (!rst && result_valid && result_ready)
      check_result(result);
  end

  // Receiver. It normally stalls at random; on a hold request it stays stalled for a
  // long stretch so that the block fills up and has to hold off its input.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        result_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        result_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("[crc8_stuffed_frame_encoder] ERROR");
    $finish;
  end

  initial begin
    in_item_t   req;
    logic [7:0] phase_blocks [6];
    int         counted;
    int         r;
    bit         held;
    bit         paused;

    for (int b = 0; b < 256; b++) begin
      if (crc8_next(8'h00, b[7:0]) == FLAG_BYTE)
        crc_gives_flag = b[7:0];
      if (crc8_next(8'h00, b[7:0]) == ESC_BYTE)
        crc_gives_esc = b[7:0];
    end

    // Directed part, with block_bytes at its reset value of four.
    // A byte with no open message is ignored.
    add_row(8'hAA, 1'b0, 16'hFFFF, 0);
    // A one-byte message of zero: one last frame whose CRC is zero.
    add_row(8'h00, 1'b1, 16'd1, 5,
            {8'h00, 8'h00, FLAG_BYTE, 8'h00, 8'h00, SEQ_LAST, FLAG_BYTE});
    // One-byte messages whose data has to be escaped.
    add_row(FLAG_BYTE, 1'b1, 16'd1);
    add_row(ESC_BYTE, 1'b1, 16'd1);
    // A zero-length start produces nothing.
    add_row(8'h55, 1'b1, 16'd0, 0);
    // Five bytes: a one-byte remainder frame, then a full last frame.
    add_row(8'hFF, 1'b1, 16'd5);
    add_row(8'h00, 1'b0, 16'd0);
    add_row(8'h80, 1'b0, 16'h1234);
    add_row(8'h7F, 1'b0, 16'd0);
    add_row(8'h01, 1'b0, 16'hFFFF);
    // A new start in the middle of a message drops the open one.
    add_row(8'h12, 1'b1, 16'd3);
    add_row(8'h34, 1'b0, 16'd0);
    add_row(8'h56, 1'b1, 16'd2);
    add_row(FLAG_BYTE, 1'b0, 16'd0);
    add_row(ESC_BYTE, 1'b0, 16'd0);
    // The longest message, cut short by a zero-length start.
    add_row(8'h00, 1'b1, 16'hFFFF);
    add_row(8'hA5, 1'b0, 16'd0);
    add_row(8'h5A, 1'b1, 16'd0, 0);
    add_row(8'h99, 1'b0, 16'd0, 0);
    // Left open half way through a frame, so the first block size change lands mid-message.
    add_row(8'h11, 1'b1, 16'd10);

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_idle_pct = 18;
    recv_idle_pct = 79;
    access_block_bytes(1'b0, 8'h00);
    foreach (directed_rows[i])
      send_request(directed_rows[i].req, directed_rows[i].typed_count,
                   directed_rows[i].typed_bytes);

    // Random part in six phases, each with its own block size; zero acts as one.
    // Messages may run across a phase boundary, so block size changes mid-message too.
    phase_blocks = '{8'd1, 8'd255, 8'd0, 8'd3, 8'd2, 8'd6};
    phase_blocks[4] = 8'($urandom_range(8, 2));
    for (int phase = 0; phase < 6; phase++) begin
      drain_results();
      repeat (SETTLE_CYCLES) @(negedge clk);
      case (phase / 2)
        0: begin
          send_idle_pct = 18;
          recv_idle_pct = 79;
        end
        1: begin
          send_idle_pct = 79;
          recv_idle_pct = 18;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      access_block_bytes(1'b1, phase_blocks[phase]);
      counted = 0;
      held = 1'b0;
      paused = 1'b0;
      while (counted < PHASE_ITEMS) begin
        if (counted == 16 && !held) begin
          held = 1'b1;
          hold_request = 1'b1;
        end
        if (counted == 32 && !paused) begin
          paused = 1'b1;
          drain_results();
        end
        req.data_byte = pick_data();
        if (msg_open && $urandom_range(99) >= 6) begin
          // Mostly well-formed messages: the next byte of the open one.
          req.start_of_message = 1'b0;
          req.message_bytes = 16'($urandom_range(16'hFFFF));
          counted++;
        end else begin
          // Otherwise a new message, a zero-length start, or a stray byte.
          r = $urandom_range(99);
          req.start_of_message = (msg_open || r >= 8);
          if (!req.start_of_message) begin
            req.message_bytes = 16'($urandom_range(16'hFFFF));
          end else if (r < 14) begin
            req.message_bytes = 16'd0;
          end else begin
            req.message_bytes = pick_length();
            counted++;
          end
        end
        send_request(req);
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (expected_bytes.size() != 0)
      report_mismatch($sformatf("%0d output bytes never arrived", expected_bytes.size()));
    if (fail_count == 0)
      $display("[crc8_stuffed_frame_encoder] OK");
    else
      $display("[crc8_stuffed_frame_encoder] ERROR");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+src
src/csfe_pkg.sv
src/csfe_ctrl.sv
src/csfe_dp.sv
src/crc8_stuffed_frame_encoder.sv
dv/testbench.sv
